// ===== rtl/hbridge_duty_ramp_overcurrent_assert.svh =====
// assertion macros for the h-bridge duty ramp block
// expects clk and arst_n in the scope of each use
`ifndef HBRIDGE_DUTY_RAMP_OVERCURRENT_ASSERT_SVH
`define HBRIDGE_DUTY_RAMP_OVERCURRENT_ASSERT_SVH

// consequent checked in the same cycle
`define HDRO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define HDRO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hdro_pkg.sv =====
// shared types and constants of the h-bridge duty ramp block
// no dependencies
`default_nettype none

package hdro_pkg;

	localparam int AVG_WINDOW_DEF = 8;
	localparam int RAMP_STEP_DEF  = 100;

	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 72;
	localparam int CMD_W    = 2;
	localparam int MV_W     = 12;
	localparam int REQ_W    = 12;
	localparam int DUTY_W   = 11;
	localparam int MAG_W    = 10;
	localparam int LEVEL_W  = 16;
	localparam int RES_W    = 17;
	localparam int SCALED_W = 23;
	localparam int PROD_W   = MAG_W + LEVEL_W;

	localparam int DUTY_FULL  = 1000;
	localparam int SENSE_GAIN = 1600;
	localparam int SCALED_MAX = 4095 * SENSE_GAIN;

	localparam logic [RES_W-1:0]    SENSE_RES_RST = 17'd1000;
	localparam logic [SCALED_W-1:0] WARN_RST      = 23'd4000;
	localparam logic [SCALED_W-1:0] ERROR_RST     = 23'd8000;
	localparam logic [LEVEL_W-1:0]  FULL_RST      = 16'd1023;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_SET   = 2'd1,
		CMD_COAST = 2'd2,
		CMD_BRAKE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_SENSE = 3'd0,
		REG_WARN  = 3'd1,
		REG_ERROR = 3'd2,
		REG_SWAP  = 3'd3,
		REG_FULL  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

`default_nettype wire

// ===== rtl/hdro_ram.sv =====
// generic single-port-write ram with registered read
// no dependencies
`default_nettype none

module hdro_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hdro_serdiv.sv =====
// restoring divider, one quotient bit per cycle
// depends on hdro_pkg
`default_nettype none

module hdro_serdiv #(
	parameter int DVD_W = 26,
	parameter int DVS_W = 17
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [DVD_W-1:0]   dividend,
	input  wire logic [DVS_W-1:0]   divisor,
	output logic      [DVD_W-1:0]   quotient,
	output hdro_pkg::unit_status_t  status
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

`default_nettype wire

// ===== rtl/hdro_sermul.sv =====
// shift-add multiplier, one multiplier bit per cycle, msb first
// depends on hdro_pkg
`default_nettype none

module hdro_sermul #(
	parameter int A_W = 10,
	parameter int B_W = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [A_W-1:0]     a,
	input  wire logic [B_W-1:0]     b,
	output logic      [A_W+B_W-1:0] product,
	output hdro_pkg::unit_status_t  status
);

	localparam int CNT_W = $clog2(A_W + 1);

	logic [A_W-1:0]     a_q;
	logic [B_W-1:0]     b_q;
	logic [A_W+B_W-1:0] acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(A_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= {a_q[A_W-2:0], 1'b0};
			acc_q <= {acc_q[A_W+B_W-2:0], 1'b0}
				+ (a_q[A_W-1] ? (A_W+B_W)'(b_q) : '0);
		end
	end

	assign product     = acc_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

`default_nettype wire

// ===== rtl/hbridge_duty_ramp_overcurrent.sv =====
// top level of the h-bridge duty ramp block with averaged current limit
// depends on hdro_pkg, hdro_ram, hdro_serdiv, hdro_sermul and the assert header
`default_nettype none

`include "hbridge_duty_ramp_overcurrent_assert.svh"

// Commands arrive one per transaction on the slave stream; each gives one status
// transaction on the master stream. Set-target and stop commands go straight to the
// output stage. A tick runs through one shared bit-serial divider three times (current
// scaling, window average, leg level, each over a DIV_W-bit dividend with DIV_W =
// max(26, 23 + log2 of AVG_WINDOW)) and once through the bit-serial multiplier; a tick
// that leaves the duty unchanged, or brings it to zero, skips the multiply and the last
// divide. The next command is taken as soon as a result sits in the output register.

module hbridge_duty_ramp_overcurrent #(
	parameter int AVG_WINDOW = hdro_pkg::AVG_WINDOW_DEF,
	parameter int RAMP_STEP  = hdro_pkg::RAMP_STEP_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [hdro_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [hdro_pkg::DATA_W-1:0]   pwdata,
	output logic      [hdro_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// sense_millivolts[11:0], duty_request[23:12]
	input  wire logic [hdro_pkg::IN_W-1:0]     s_axis_tdata,
	// command[1:0]
	input  wire logic [hdro_pkg::CMD_W-1:0]    s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// forward_level[15:0], reverse_level[31:16], duty_now[42:32],
	// current_average[65:43], over_error[66], over_warning[67], is_stopped[68]
	output logic      [hdro_pkg::OUT_W-1:0]    m_axis_tdata
);

	localparam int SLOT_W = AVG_WINDOW > 1 ? $clog2(AVG_WINDOW) : 1;
	localparam int SUM_W  = hdro_pkg::SCALED_W + $clog2(AVG_WINDOW);
	localparam int DIV_W  = SUM_W > hdro_pkg::PROD_W ? SUM_W : hdro_pkg::PROD_W;
	localparam int SW     = hdro_pkg::SCALED_W;
	localparam int DW     = hdro_pkg::DUTY_W;
	localparam int LW     = hdro_pkg::LEVEL_W;
	localparam int RW     = hdro_pkg::RES_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCALE,
		S_AVG_GO,
		S_AVG,
		S_DUTY,
		S_MUL_GO,
		S_MUL,
		S_LVL,
		S_DONE
	} state_t;

	// configuration registers
	logic [RW-1:0] sense_res_q;
	logic [SW-1:0] warn_level_q;
	logic [SW-1:0] error_level_q;
	logic          swap_q;
	logic [LW-1:0] full_scale_q;
	logic          cfg_wr;

	// block state
	state_t                 state_q;
	logic signed [DW-1:0]   duty_target_q;
	logic signed [DW-1:0]   duty_actual_q;
	logic [LW-1:0]          fwd_q;
	logic [LW-1:0]          rev_q;
	logic                   halted_q;
	logic [SUM_W-1:0]       ring_sum_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [AVG_WINDOW-1:0]  valid_q;
	logic [SW-1:0]          avg_q;
	logic [1:0]             flag_q;
	logic                   m_valid_q;
	logic [hdro_pkg::OUT_W-1:0] out_data_q;

	// unit control
	logic                       div_start_q;
	logic [DIV_W-1:0]           div_dvd_q;
	logic [RW-1:0]              div_dvs_q;
	logic [DIV_W-1:0]           div_quo;
	hdro_pkg::unit_status_t     div_stat;
	logic                       mul_start_q;
	logic [hdro_pkg::MAG_W-1:0] mul_a_q;
	logic [hdro_pkg::PROD_W-1:0] mul_prod;
	hdro_pkg::unit_status_t     mul_stat;

	// input decode
	logic                          in_accept;
	hdro_pkg::cmd_t                cmd;
	logic [hdro_pkg::MV_W-1:0]     in_mv;
	logic signed [hdro_pkg::REQ_W-1:0] in_req;
	logic signed [DW-1:0]          req_clamped;
	logic [SW-1:0]                 sense_num;

	// ring access
	logic [SW-1:0] ring_rd;
	logic [SW-1:0] ring_old;
	logic [SW-1:0] scaled;

	// duty update
	logic signed [11:0] act_x;
	logic signed [11:0] tgt_x;
	logic signed [11:0] act_mag;
	logic signed [11:0] tgt_mag;
	logic signed [11:0] delta;
	logic signed [11:0] delta_mag;
	logic signed [11:0] ramp_x;
	logic signed [11:0] step_x;
	logic               sign_change;
	logic signed [DW-1:0] duty_next;
	logic               leg_reverse;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sense_res_q   <= hdro_pkg::SENSE_RES_RST;
			warn_level_q  <= hdro_pkg::WARN_RST;
			error_level_q <= hdro_pkg::ERROR_RST;
			swap_q        <= 1'b0;
			full_scale_q  <= hdro_pkg::FULL_RST;
		end else if (cfg_wr) begin
			unique case (hdro_pkg::reg_idx_t'(paddr[4:2]))
				hdro_pkg::REG_SENSE: sense_res_q   <= pwdata[RW-1:0];
				hdro_pkg::REG_WARN:  warn_level_q  <= pwdata[SW-1:0];
				hdro_pkg::REG_ERROR: error_level_q <= pwdata[SW-1:0];
				hdro_pkg::REG_SWAP:  swap_q        <= pwdata[0];
				hdro_pkg::REG_FULL:  full_scale_q  <= pwdata[LW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (hdro_pkg::reg_idx_t'(paddr[4:2]))
			hdro_pkg::REG_SENSE: prdata = 32'(sense_res_q);
			hdro_pkg::REG_WARN:  prdata = 32'(warn_level_q);
			hdro_pkg::REG_ERROR: prdata = 32'(error_level_q);
			hdro_pkg::REG_SWAP:  prdata = 32'(swap_q);
			hdro_pkg::REG_FULL:  prdata = 32'(full_scale_q);
			default:             prdata = '0;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid & s_axis_tready;
	assign cmd           = hdro_pkg::cmd_t'(s_axis_tuser);
	assign in_mv         = s_axis_tdata[11:0];
	assign in_req        = s_axis_tdata[23:12];

	// mv * 1600 as three shifted terms
	assign sense_num = SW'({in_mv, 10'b0}) + SW'({in_mv, 9'b0}) + SW'({in_mv, 6'b0});

	always_comb begin
		if (in_req > 12'sd1000) begin
			req_clamped = 11'sd1000;
		end else if (in_req < -12'sd1000) begin
			req_clamped = -11'sd1000;
		end else begin
			req_clamped = DW'(in_req);
		end
	end

	hdro_ram #(
		.WIDTH(SW),
		.DEPTH(AVG_WINDOW)
	) u_ring (
		.clk    (clk),
		.wr_en  (state_q == S_SCALE && div_stat.done),
		.wr_addr(slot_q),
		.wr_data(scaled),
		.rd_en  (in_accept),
		.rd_addr(slot_q),
		.rd_data(ring_rd)
	);

	assign ring_old = valid_q[slot_q] ? ring_rd : '0;
	assign scaled   = div_quo[SW-1:0];

	hdro_serdiv #(
		.DVD_W(DIV_W),
		.DVS_W(RW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.dividend(div_dvd_q),
		.divisor (div_dvs_q),
		.quotient(div_quo),
		.status  (div_stat)
	);

	hdro_sermul #(
		.A_W(hdro_pkg::MAG_W),
		.B_W(LW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (full_scale_q),
		.product(mul_prod),
		.status (mul_stat)
	);

	always_comb begin
		act_x       = {duty_actual_q[DW-1], duty_actual_q};
		tgt_x       = {duty_target_q[DW-1], duty_target_q};
		act_mag     = act_x[11] ? -act_x : act_x;
		tgt_mag     = tgt_x[11] ? -tgt_x : tgt_x;
		delta       = tgt_x - act_x;
		delta_mag   = delta[11] ? -delta : delta;
		ramp_x      = 12'(RAMP_STEP);
		step_x      = (delta_mag < ramp_x) ? delta_mag : ramp_x;
		sign_change = (act_x[11] && tgt_x > 12'sd0) || (act_x > 12'sd0 && tgt_x[11]);
		if (sign_change) begin
			duty_next = '0;
		end else if (tgt_mag < act_mag) begin
			duty_next = duty_target_q;
		end else if (delta[11]) begin
			duty_next = DW'(act_x - step_x);
		end else begin
			duty_next = DW'(act_x + step_x);
		end
	end

	assign leg_reverse = duty_actual_q[DW-1] ^ swap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			duty_target_q <= '0;
			duty_actual_q <= '0;
			fwd_q         <= '0;
			rev_q         <= '0;
			halted_q      <= 1'b1;
			ring_sum_q    <= '0;
			slot_q        <= '0;
			valid_q       <= '0;
			avg_q         <= '0;
			flag_q        <= '0;
			m_valid_q     <= 1'b0;
			out_data_q    <= '0;
			div_start_q   <= 1'b0;
			div_dvd_q     <= '0;
			div_dvs_q     <= '0;
			mul_start_q   <= 1'b0;
			mul_a_q       <= '0;
		end else begin
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_DONE;
						unique case (cmd)
							hdro_pkg::CMD_TICK: begin
								div_start_q <= 1'b1;
								div_dvd_q   <= DIV_W'(sense_num);
								div_dvs_q   <= (sense_res_q == '0) ? RW'(1) : sense_res_q;
								state_q     <= S_SCALE;
							end
							hdro_pkg::CMD_SET: begin
								duty_target_q <= req_clamped;
							end
							hdro_pkg::CMD_COAST: begin
								duty_target_q <= '0;
								duty_actual_q <= '0;
								fwd_q         <= '0;
								rev_q         <= '0;
								halted_q      <= 1'b1;
							end
							hdro_pkg::CMD_BRAKE: begin
								duty_target_q <= '0;
								duty_actual_q <= '0;
								fwd_q         <= full_scale_q;
								rev_q         <= full_scale_q;
								halted_q      <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_SCALE: begin
					if (div_stat.done) begin
						ring_sum_q      <= ring_sum_q - SUM_W'(ring_old) + SUM_W'(scaled);
						valid_q[slot_q] <= 1'b1;
						slot_q          <= (slot_q == SLOT_W'(AVG_WINDOW - 1)) ? '0
							: slot_q + 1'b1;
						state_q         <= S_AVG_GO;
					end
				end
				S_AVG_GO: begin
					div_start_q <= 1'b1;
					div_dvd_q   <= DIV_W'(ring_sum_q);
					div_dvs_q   <= RW'(AVG_WINDOW);
					state_q     <= S_AVG;
				end
				S_AVG: begin
					if (div_stat.done) begin
						avg_q   <= div_quo[SW-1:0];
						state_q <= S_DUTY;
					end
				end
				S_DUTY: begin
					flag_q <= {avg_q >= error_level_q, avg_q >= warn_level_q};
					if (duty_target_q != duty_actual_q) begin
						duty_actual_q <= duty_next;
						state_q       <= S_MUL_GO;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MUL_GO: begin
					if (duty_actual_q == '0) begin
						halted_q <= 1'b1;
						fwd_q    <= full_scale_q;
						rev_q    <= full_scale_q;
						state_q  <= S_DONE;
					end else begin
						mul_start_q <= 1'b1;
						mul_a_q     <= hdro_pkg::MAG_W'(act_mag);
						state_q     <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_stat.done) begin
						div_start_q <= 1'b1;
						div_dvd_q   <= DIV_W'(mul_prod);
						div_dvs_q   <= RW'(hdro_pkg::DUTY_FULL);
						state_q     <= S_LVL;
					end
				end
				S_LVL: begin
					if (div_stat.done) begin
						halted_q <= 1'b0;
						if (leg_reverse) begin
							rev_q <= div_quo[LW-1:0];
							fwd_q <= '0;
						end else begin
							fwd_q <= div_quo[LW-1:0];
							rev_q <= '0;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q  <= 1'b1;
						out_data_q <= {3'b0, halted_q, flag_q[0], flag_q[1], avg_q,
							duty_actual_q, rev_q, fwd_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;

	`HDRO_ASSERT_NOW(a_halt_matches_duty, state_q == S_IDLE,
		halted_q == (duty_actual_q == '0), "halted flag disagrees with duty")
	`HDRO_ASSERT_NOW(a_duty_range, 1'b1,
		duty_actual_q <= 11'sd1000 && duty_actual_q >= -11'sd1000, "duty out of range")
	`HDRO_ASSERT_NOW(a_avg_bound, 1'b1,
		avg_q <= SW'(hdro_pkg::SCALED_MAX), "average above largest sample")
	`HDRO_ASSERT_NOW(a_units_quiet, state_q == S_IDLE || state_q == S_DONE,
		!div_stat.busy && !mul_stat.busy, "arithmetic unit busy between commands")
	`HDRO_ASSERT_NEXT(a_tick_starts_div, in_accept && cmd == hdro_pkg::CMD_TICK,
		div_start_q && state_q == S_SCALE, "tick did not start the divider")

endmodule

`default_nettype wire

// ===== dv/tb_hbridge_duty_ramp_overcurrent.sv =====
// self-checking testbench for the h-bridge duty ramp block with averaged current limit
// drives commands on the slave stream and registers over apb, checks each status transaction
// depends on hdro_pkg and the hbridge_duty_ramp_overcurrent rtl
`timescale 1ns / 100ps

module tb_hbridge_duty_ramp_overcurrent;
	import hdro_pkg::*;

	localparam int WINDOW      = AVG_WINDOW_DEF;
	localparam int STEP        = RAMP_STEP_DEF;
	localparam int AVG_MAX     = 8388607;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 150;

	typedef struct packed {
		logic [2:0]          pad;
		logic                is_stopped;
		logic                over_warning;
		logic                over_error;
		logic [SCALED_W-1:0] current_average;
		logic [DUTY_W-1:0]   duty_now;
		logic [LEVEL_W-1:0]  reverse_level;
		logic [LEVEL_W-1:0]  forward_level;
	} bridge_status_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	// sense_millivolts[11:0], duty_request[23:12]
	logic [IN_W-1:0]     s_axis_tdata;
	// command[1:0]
	logic [CMD_W-1:0]    s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// forward_level[15:0], reverse_level[31:16], duty_now[42:32],
	// current_average[65:43], over_error[66], over_warning[67], is_stopped[68]
	logic [OUT_W-1:0]    m_axis_tdata;

	hbridge_duty_ramp_overcurrent DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// predictor copy of the registers
	logic [RES_W-1:0]    cfg_sense_res;
	logic [SCALED_W-1:0] cfg_warn_level;
	logic [SCALED_W-1:0] cfg_error_level;
	logic                cfg_swap;
	logic [LEVEL_W-1:0]  cfg_full_scale;

	// predictor copy of the bridge state
	logic signed [DUTY_W-1:0] duty_target;
	logic signed [DUTY_W-1:0] duty_actual;
	logic [LEVEL_W-1:0]       fwd_drive;
	logic [LEVEL_W-1:0]       rev_drive;
	logic                     halted;
	logic [SCALED_W-1:0]      sample_ring [WINDOW];
	logic [25:0]              ring_sum;
	int unsigned              ring_slot;
	logic                     warn_flag;
	logic                     error_flag;

	bridge_status_t status_q[$];

	int error_count;
	int cycle_count;
	int items_sent;
	int reg_writes;
	int send_idle_pct;
	int recv_stall_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : status_checker
		bridge_status_t got;
		bridge_status_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = bridge_status_t'(m_axis_tdata);
			if (status_q.size() == 0) begin
				$error("status transaction with no command pending: %h", m_axis_tdata);
				error_count++;
			end else begin
				want = status_q.pop_front();
				check_field("forward_level", want.forward_level, got.forward_level);
				check_field("reverse_level", want.reverse_level, got.reverse_level);
				check_field("duty_now", int'($signed(want.duty_now)),
					int'($signed(got.duty_now)));
				check_field("current_average", want.current_average, got.current_average);
				check_field("over_error", want.over_error, got.over_error);
				check_field("over_warning", want.over_warning, got.over_warning);
				check_field("is_stopped", want.is_stopped, got.is_stopped);
			end
		end
	end

	function automatic void reset_bridge_model();
		cfg_sense_res   = SENSE_RES_RST;
		cfg_warn_level  = WARN_RST;
		cfg_error_level = ERROR_RST;
		cfg_swap        = 1'b0;
		cfg_full_scale  = FULL_RST;
		duty_target     = '0;
		duty_actual     = '0;
		fwd_drive       = '0;
		rev_drive       = '0;
		halted          = 1'b1;
		foreach (sample_ring[i])
			sample_ring[i] = '0;
		ring_sum   = '0;
		ring_slot  = 0;
		warn_flag  = 1'b0;
		error_flag = 1'b0;
	endfunction

	function automatic void update_legs();
		int mag;
		int directed;
		logic [LEVEL_W-1:0] level;
		mag      = (duty_actual < 0) ? -int'(duty_actual) : int'(duty_actual);
		level    = LEVEL_W'((longint'(mag) * longint'(cfg_full_scale)) / DUTY_FULL);
		directed = cfg_swap ? -int'(duty_actual) : int'(duty_actual);
		if (directed < 0) begin
			rev_drive = level;
			fwd_drive = '0;
			halted    = 1'b0;
		end else if (directed > 0) begin
			fwd_drive = level;
			rev_drive = '0;
			halted    = 1'b0;
		end else begin
			halted    = 1'b1;
			fwd_drive = cfg_full_scale;
			rev_drive = cfg_full_scale;
		end
	endfunction

	function automatic void apply_tick(input logic [MV_W-1:0] mv);
		longint unsigned divisor;
		longint unsigned scaled;
		int avg;
		int act;
		int tgt;
		int delta;
		int mag_delta;
		int stride;
		divisor = (cfg_sense_res == 0) ? 1 : cfg_sense_res;
		scaled  = (longint'(mv) * SENSE_GAIN) / divisor;
		if (scaled > AVG_MAX)
			scaled = AVG_MAX;
		ring_sum = ring_sum - sample_ring[ring_slot] + 26'(scaled);
		sample_ring[ring_slot] = SCALED_W'(scaled);
		ring_slot  = (ring_slot + 1) % WINDOW;
		avg        = int'(ring_sum / WINDOW);
		warn_flag  = (avg >= int'(cfg_warn_level));
		error_flag = (avg >= int'(cfg_error_level));
		act = int'(duty_actual);
		tgt = int'(duty_target);
		if (tgt != act) begin
			if ((act < 0 && tgt > 0) || (act > 0 && tgt < 0)) begin
				act = 0;
			end else if ((tgt < 0 ? -tgt : tgt) < (act < 0 ? -act : act)) begin
				act = tgt;
			end else begin
				delta     = tgt - act;
				mag_delta = (delta < 0) ? -delta : delta;
				stride    = (mag_delta < STEP) ? mag_delta : STEP;
				act       = act + ((delta < 0) ? -stride : stride);
			end
			duty_actual = DUTY_W'(act);
			update_legs();
		end
	endfunction

	function automatic bridge_status_t predict_status(input cmd_t cmd,
			input logic [MV_W-1:0] mv, input logic [REQ_W-1:0] req);
		bridge_status_t st;
		int target;
		case (cmd)
			CMD_TICK: begin
				apply_tick(mv);
			end
			CMD_SET: begin
				target = int'($signed(req));
				if (target > DUTY_FULL)
					target = DUTY_FULL;
				if (target < -DUTY_FULL)
					target = -DUTY_FULL;
				duty_target = DUTY_W'(target);
			end
			default: begin
				duty_actual = '0;
				duty_target = '0;
				if (cmd == CMD_COAST) begin
					fwd_drive = '0;
					rev_drive = '0;
				end else begin
					fwd_drive = cfg_full_scale;
					rev_drive = cfg_full_scale;
				end
				halted = 1'b1;
			end
		endcase
		st                 = '0;
		st.forward_level   = fwd_drive;
		st.reverse_level   = rev_drive;
		st.duty_now        = duty_actual;
		st.current_average = SCALED_W'(ring_sum / WINDOW);
		st.over_error      = error_flag;
		st.over_warning    = warn_flag;
		st.is_stopped      = halted;
		return st;
	endfunction

	task automatic send_command(input cmd_t cmd, input logic [MV_W-1:0] mv,
			input logic [REQ_W-1:0] req);
		bit taken;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {req, mv};
		s_axis_tuser  = cmd;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = s_axis_tready;
		end
		status_q.push_back(predict_status(cmd, mv, req));
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (status_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_W'(idx) << 2;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_SENSE: cfg_sense_res   = value[RES_W-1:0];
			REG_WARN:  cfg_warn_level  = value[SCALED_W-1:0];
			REG_ERROR: cfg_error_level = value[SCALED_W-1:0];
			REG_SWAP:  cfg_swap        = value[0];
			REG_FULL:  cfg_full_scale  = value[LEVEL_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic write_all_regs(input logic [RES_W-1:0] sense_res,
			input logic [SCALED_W-1:0] warn_level, input logic [SCALED_W-1:0] err_level,
			input logic swap, input logic [LEVEL_W-1:0] full_scale);
		write_reg(REG_SENSE, DATA_W'(sense_res));
		write_reg(REG_WARN, DATA_W'(warn_level));
		write_reg(REG_ERROR, DATA_W'(err_level));
		write_reg(REG_SWAP, DATA_W'(swap));
		write_reg(REG_FULL, DATA_W'(full_scale));
	endtask

	// mostly ticks so the ramp gets somewhere, with target changes and the odd stop
	task automatic send_random_commands(input int count);
		int pick;
		cmd_t cmd;
		logic [MV_W-1:0] mv;
		logic [REQ_W-1:0] req;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 55)
				cmd = CMD_TICK;
			else if (pick < 85)
				cmd = CMD_SET;
			else if (pick < 93)
				cmd = CMD_COAST;
			else
				cmd = CMD_BRAKE;
			mv = ($urandom_range(3) == 0) ? MV_W'($urandom_range(15)) : MV_W'($urandom);
			if ($urandom_range(1) == 0)
				req = REQ_W'($urandom_range(2 * DUTY_FULL) - DUTY_FULL);
			else
				req = REQ_W'($urandom);
			send_command(cmd, mv, req);
		end
	endtask

	task automatic test_directed_commands();
		send_command(CMD_TICK, 12'd0, 12'd0);
		send_command(CMD_TICK, 12'hFFF, 12'hFFF);
		send_command(CMD_SET, 12'hFFF, 12'h7FF);
		repeat (3) send_command(CMD_TICK, 12'hFFF, 12'd0);
		send_command(CMD_SET, 12'd0, 12'h800);
		send_command(CMD_TICK, 12'hFFF, 12'd0);
		send_command(CMD_TICK, 12'hFFF, 12'd0);
		send_command(CMD_SET, 12'd0, -12'sd50);
		send_command(CMD_TICK, 12'hFFF, 12'd0);
		send_command(CMD_SET, 12'd0, 12'd0);
		send_command(CMD_TICK, 12'hFFF, 12'd0);
		send_command(CMD_TICK, 12'd0, 12'd0);
		send_command(CMD_SET, 12'd0, 12'd1000);
		send_command(CMD_TICK, 12'd0, 12'd0);
		send_command(CMD_BRAKE, 12'hFFF, 12'hFFF);
		send_command(CMD_TICK, 12'd0, 12'd0);
		send_command(CMD_SET, 12'd0, -12'sd1);
		send_command(CMD_TICK, 12'd0, 12'd0);
		send_command(CMD_COAST, 12'd0, 12'd0);
		send_command(CMD_SET, 12'd0, -12'sd1000);
		send_command(CMD_TICK, 12'hFFF, 12'd0);
		send_command(CMD_SET, 12'd0, 12'd999);
		send_command(CMD_TICK, 12'd1, 12'd0);
		wait_drained();
	endtask

	task automatic test_register_extremes();
		// zero sense resistor divides by one, zero warning level, all-ones error level, widest legs, swapped
		write_all_regs('0, '0, '1, 1'b1, '1);
		send_random_commands(40);
		wait_drained();
		write_all_regs('1, '1, '0, 1'b0, '0);
		send_random_commands(40);
		wait_drained();
		write_all_regs(17'd1, 23'd3276000, 23'd6552000, 1'b1, 16'd1);
		send_random_commands(40);
		wait_drained();
	endtask

	task automatic test_random_stream();
		int send_mix [4] = '{0, 67, 0, 23};
		int recv_mix [4] = '{0, 0, 67, 23};
		int top_avg;
		logic [RES_W-1:0] sense_res;
		for (int mode = 0; mode < 4; mode++) begin
			send_idle_pct  = send_mix[mode];
			recv_stall_pct = recv_mix[mode];
			for (int k = 0; k < 2; k++) begin
				// levels drawn inside the reachable current range so both flags move
				sense_res = ($urandom_range(2) == 0) ? RES_W'($urandom_range(1, 50))
					: RES_W'($urandom_range(1, 100000));
				top_avg = (4095 * SENSE_GAIN) / sense_res;
				write_all_regs(sense_res, SCALED_W'($urandom_range(0, top_avg)),
					SCALED_W'($urandom_range(0, top_avg)), 1'($urandom),
					LEVEL_W'($urandom_range(1, 65535)));
				send_random_commands(200);
				wait_drained();
			end
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = CMD_TICK;
		m_axis_tready  = 1'b0;
		error_count    = 0;
		cycle_count    = 0;
		items_sent     = 0;
		reg_writes     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		reset_bridge_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_commands();
		test_register_extremes();
		test_random_stream();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (status_q.size() != 0) begin
			$error("%0d status transactions never arrived", status_q.size());
			error_count++;
		end
		$display("ran %0d commands (ticks, targets, coast and brake stops) through %0d register writes",
			items_sent, reg_writes);
		$display("with streams both free-running and throttled on either side");
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
